/* design/pcf_pkg.sv */
// Shared types and constants for the fixed-point correlation core.
`timescale 1ns / 1ps
`default_nettype none
package pcf_pkg;

  localparam int DEF_MAX_PAIRS   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int FRAC_BITS = 15;
  localparam int CORR_W    = FRAC_BITS + 1;
  localparam int QUO_W     = 2 * FRAC_BITS + 1;
  localparam int ROOT_W    = FRAC_BITS + 1;
  localparam int DCNT_W    = $clog2(QUO_W);
  localparam int SCNT_W    = $clog2(ROOT_W);

  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};

  typedef enum logic [3:0] {
    STEP_NSXY,
    STEP_SXSY,
    STEP_NSXX,
    STEP_SXSX,
    STEP_NSYY,
    STEP_SYSY,
    STEP_VXVY,
    STEP_COV2,
    STEP_DIV,
    STEP_SQRT
  } step_t;

  typedef struct packed {
    logic  accum;
    logic  go;
    step_t step;
    logic  load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic degen;
  } status_t;

endpackage
`default_nettype wire

/* design/pcf_datapath.sv */
// Datapath: running sums, shared serial multiplier, divider, root search, result register.
`timescale 1ns / 1ps
`default_nettype none
module pcf_datapath #(
  parameter int MAX_PAIRS   = pcf_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pcf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pcf_pkg::cmd_t                      cmd,
  output pcf_pkg::status_t                   status,
  input  logic [SAMPLE_BITS-1:0]             x_sample,
  input  logic [SAMPLE_BITS-1:0]             y_sample,
  output logic signed [pcf_pkg::CORR_W-1:0]  correlation,
  output logic [$clog2(MAX_PAIRS+1)-1:0]     pair_count,
  output logic                               degenerate,
  output logic                               overflowed
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int SP_W  = SQ_W + 1;
  localparam int MAG_W = 2 * SAMPLE_BITS + 2 * CNT_W - 2;
  localparam int PRD_W = 2 * MAG_W;
  localparam int DVD_W = PRD_W + 2 * pcf_pkg::FRAC_BITS;

  // running sums
  logic signed [SX_W-1:0] sum_x, sum_y;
  logic [SQ_W-1:0]        sum_xx, sum_yy;
  logic signed [SP_W-1:0] sum_xy;
  logic [CNT_W-1:0]       pairs;
  logic                   cap;

  logic signed [SAMPLE_BITS-1:0]   xs, ys;
  logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

  assign xs = signed'(x_sample);
  assign ys = signed'(y_sample);
  assign xx = xs * xs;
  assign yy = ys * ys;
  assign xy = xs * ys;

  // moments
  logic signed [MAG_W:0]   t1;
  logic signed [MAG_W+1:0] cov;
  logic [MAG_W-1:0]        vx, vy;

  logic [MAG_W-1:0] n_ext, ax, ay, axy, acov;
  assign n_ext = MAG_W'(pairs);
  assign ax    = sum_x[SX_W-1]  ? MAG_W'(unsigned'(-sum_x))  : MAG_W'(unsigned'(sum_x));
  assign ay    = sum_y[SX_W-1]  ? MAG_W'(unsigned'(-sum_y))  : MAG_W'(unsigned'(sum_y));
  assign axy   = sum_xy[SP_W-1] ? MAG_W'(unsigned'(-sum_xy)) : MAG_W'(unsigned'(sum_xy));
  assign acov  = cov[MAG_W+1]   ? MAG_W'(unsigned'(-cov))    : MAG_W'(unsigned'(cov));

  // serial multiplier
  logic [PRD_W-1:0]   mc, acc;
  logic [MAG_W-1:0]   mp;
  logic               mul_busy, mul_neg;
  pcf_pkg::step_t     mul_step;
  logic [MAG_W-1:0]   opa, opb;
  logic               op_neg;
  logic               mul_end;

  always_comb begin
    opa    = n_ext;
    opb    = axy;
    op_neg = 1'b0;
    case (cmd.step)
      pcf_pkg::STEP_NSXY: begin
        opa = n_ext; opb = axy; op_neg = sum_xy[SP_W-1];
      end
      pcf_pkg::STEP_SXSY: begin
        opa = ax; opb = ay; op_neg = sum_x[SX_W-1] ^ sum_y[SX_W-1];
      end
      pcf_pkg::STEP_NSXX: begin
        opa = n_ext; opb = MAG_W'(sum_xx);
      end
      pcf_pkg::STEP_SXSX: begin
        opa = ax; opb = ax;
      end
      pcf_pkg::STEP_NSYY: begin
        opa = n_ext; opb = MAG_W'(sum_yy);
      end
      pcf_pkg::STEP_SYSY: begin
        opa = ay; opb = ay;
      end
      pcf_pkg::STEP_VXVY: begin
        opa = vx; opb = vy;
      end
      pcf_pkg::STEP_COV2: begin
        opa = acov; opb = acov;
      end
      default: begin
        opa = n_ext; opb = axy;
      end
    endcase
  end

  assign mul_end = mul_busy && (mp == '0);

  logic signed [MAG_W:0] sprod_pos, sprod, t1_diff;
  assign sprod_pos = signed'({1'b0, acc[MAG_W-1:0]});
  assign sprod     = mul_neg ? -sprod_pos : sprod_pos;
  assign t1_diff   = t1 - sprod;

  // divider and root search
  logic [DVD_W-1:0]                 rem, dsh;
  logic [pcf_pkg::QUO_W-1:0]        quo;
  logic [pcf_pkg::DCNT_W-1:0]       dcnt;
  logic                             div_busy, div_ge;
  logic [pcf_pkg::ROOT_W-1:0]       root, cand;
  logic [2*pcf_pkg::ROOT_W-1:0]     cand_sq;
  logic [pcf_pkg::SCNT_W-1:0]       scnt;
  logic                             sq_busy, sq_fit;
  logic                             done;

  assign div_ge  = (dsh <= rem);
  assign cand    = root | (pcf_pkg::ROOT_W'(1) << scnt);
  assign cand_sq = cand * cand;
  assign sq_fit  = (cand_sq <= (2*pcf_pkg::ROOT_W)'(quo));

  logic                             degen;
  logic [pcf_pkg::CORR_W-1:0]       corr_val;
  assign degen = (vx == '0) || (vy == '0);

  always_comb begin
    if (degen) begin
      corr_val = '0;
    end else if (cov[MAG_W+1]) begin
      corr_val = pcf_pkg::CORR_W'(~root + pcf_pkg::ROOT_W'(1));
    end else if (root[pcf_pkg::ROOT_W-1]) begin
      corr_val = pcf_pkg::CORR_MAX;
    end else begin
      corr_val = pcf_pkg::CORR_W'(root);
    end
  end

  assign status.done  = done;
  assign status.degen = degen;

  // control and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xx   <= '0;
      sum_yy   <= '0;
      sum_xy   <= '0;
      pairs    <= '0;
      cap      <= 1'b0;
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      sq_busy  <= 1'b0;
      dcnt     <= '0;
      scnt     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        sum_x  <= '0;
        sum_y  <= '0;
        sum_xx <= '0;
        sum_yy <= '0;
        sum_xy <= '0;
        pairs  <= '0;
        cap    <= 1'b0;
      end else if (cmd.accum) begin
        if (pairs < CNT_W'(MAX_PAIRS)) begin
          pairs  <= pairs + CNT_W'(1);
          sum_x  <= sum_x + SX_W'(xs);
          sum_y  <= sum_y + SX_W'(ys);
          sum_xx <= sum_xx + SQ_W'(unsigned'(xx));
          sum_yy <= sum_yy + SQ_W'(unsigned'(yy));
          sum_xy <= sum_xy + SP_W'(xy);
        end else begin
          cap <= 1'b1;
        end
      end
      if (cmd.go) begin
        case (cmd.step)
          pcf_pkg::STEP_DIV: begin
            div_busy <= 1'b1;
            dcnt     <= pcf_pkg::DCNT_W'(pcf_pkg::QUO_W - 1);
          end
          pcf_pkg::STEP_SQRT: begin
            sq_busy <= 1'b1;
            scnt    <= pcf_pkg::SCNT_W'(pcf_pkg::ROOT_W - 1);
          end
          default: mul_busy <= 1'b1;
        endcase
      end
      if (mul_end) begin
        mul_busy <= 1'b0;
        done     <= 1'b1;
      end
      if (div_busy) begin
        if (dcnt == '0) begin
          div_busy <= 1'b0;
          done     <= 1'b1;
        end else begin
          dcnt <= dcnt - pcf_pkg::DCNT_W'(1);
        end
      end
      if (sq_busy) begin
        if (scnt == '0) begin
          sq_busy <= 1'b0;
          done    <= 1'b1;
        end else begin
          scnt <= scnt - pcf_pkg::SCNT_W'(1);
        end
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (cmd.step)
        pcf_pkg::STEP_DIV: quo <= '0;
        pcf_pkg::STEP_SQRT: root <= '0;
        default: begin
          mc       <= PRD_W'(opa);
          mp       <= opb;
          acc      <= '0;
          mul_neg  <= op_neg;
          mul_step <= cmd.step;
        end
      endcase
    end
    if (mul_busy && !mul_end) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
    if (mul_end) begin
      case (mul_step)
        pcf_pkg::STEP_NSXY, pcf_pkg::STEP_NSXX, pcf_pkg::STEP_NSYY: t1 <= sprod;
        pcf_pkg::STEP_SXSY: cov <= (MAG_W+2)'(t1) - (MAG_W+2)'(sprod);
        pcf_pkg::STEP_SXSX: vx <= t1_diff[MAG_W-1:0];
        pcf_pkg::STEP_SYSY: vy <= t1_diff[MAG_W-1:0];
        pcf_pkg::STEP_VXVY: dsh <= {acc, {(2*pcf_pkg::FRAC_BITS){1'b0}}};
        pcf_pkg::STEP_COV2: rem <= {acc, {(2*pcf_pkg::FRAC_BITS){1'b0}}};
        default: t1 <= t1;
      endcase
    end
    if (div_busy) begin
      if (div_ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[pcf_pkg::QUO_W-2:0], div_ge};
      dsh <= dsh >> 1;
    end
    if (sq_busy && sq_fit) begin
      root <= cand;
    end
    if (cmd.load) begin
      correlation <= signed'(corr_val);
      pair_count  <= pairs;
      degenerate  <= degen;
      overflowed  <= cap;
    end
  end

endmodule
`default_nettype wire

/* design/pcf_ctrl.sv */
// Controller: sequences accumulation, the finishing arithmetic and the result handshake.
`timescale 1ns / 1ps
`default_nettype none
module pcf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_sample,
  input  logic               out_stall,
  input  pcf_pkg::status_t   status,
  output pcf_pkg::cmd_t      cmd,
  output logic               in_stall,
  output logic               out_valid
);

  typedef enum logic [1:0] {
    S_ACCUM,
    S_RUN,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t         state;
  logic           go;
  pcf_pkg::step_t step;
  logic           accept, load;

  function automatic pcf_pkg::step_t next_step(input pcf_pkg::step_t s);
    pcf_pkg::step_t n;
    case (s)
      pcf_pkg::STEP_NSXY: n = pcf_pkg::STEP_SXSY;
      pcf_pkg::STEP_SXSY: n = pcf_pkg::STEP_NSXX;
      pcf_pkg::STEP_NSXX: n = pcf_pkg::STEP_SXSX;
      pcf_pkg::STEP_SXSX: n = pcf_pkg::STEP_NSYY;
      pcf_pkg::STEP_NSYY: n = pcf_pkg::STEP_SYSY;
      pcf_pkg::STEP_VXVY: n = pcf_pkg::STEP_COV2;
      pcf_pkg::STEP_COV2: n = pcf_pkg::STEP_DIV;
      pcf_pkg::STEP_DIV:  n = pcf_pkg::STEP_SQRT;
      default:            n = pcf_pkg::STEP_NSXY;
    endcase
    return n;
  endfunction

  assign in_stall = (state != S_ACCUM);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == S_FINISH) && (!out_valid || !out_stall);

  assign cmd.accum = accept;
  assign cmd.go    = go;
  assign cmd.step  = step;
  assign cmd.load  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      go        <= 1'b0;
      step      <= pcf_pkg::STEP_NSXY;
      out_valid <= 1'b0;
    end else begin
      go <= 1'b0;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACCUM: begin
          if (accept && last_sample) begin
            go    <= 1'b1;
            step  <= pcf_pkg::STEP_NSXY;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (status.done) begin
            case (step)
              pcf_pkg::STEP_SYSY: state <= S_CHECK;
              pcf_pkg::STEP_SQRT: state <= S_FINISH;
              default: begin
                step <= next_step(step);
                go   <= 1'b1;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (status.degen) begin
            state <= S_FINISH;
          end else begin
            step  <= pcf_pkg::STEP_VXVY;
            go    <= 1'b1;
            state <= S_RUN;
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_ACCUM;
          end
        end
        default: state <= S_ACCUM;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/pearson_correlation_fixed_core.sv */
// Top level of the fixed-point Pearson correlation core.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one signed (x, y) pair per cycle and keeps exact sums of x, y, x*x, y*y and
// x*y plus a pair count; pairs past MAX_PAIRS are dropped and reported through
// overflowed. A request with last_sample high closes the set: the core then stalls its
// input while it forms covariance and both variances, and answers the coefficient in
// Q1.15, truncated toward zero (0 with degenerate set when either variance is zero).
// Closing a set runs eight passes of a shared shift-add multiplier, each of which stops
// at the top set bit of its second operand, so small samples close sooner, and then a
// restoring division and a bitwise root search, with a handoff through the controller
// after each of them. A degenerate set skips the last two passes, the division and the
// root search. The result sits in an output register, so the next set may start
// accumulating while it waits to be taken.
module pearson_correlation_fixed_core #(
  parameter int MAX_PAIRS   = pcf_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pcf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      x_sample,
  input  logic signed [SAMPLE_BITS-1:0]      y_sample,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pcf_pkg::CORR_W-1:0]  correlation,
  output logic [$clog2(MAX_PAIRS+1)-1:0]     pair_count,
  output logic                               degenerate,
  output logic                               overflowed
);

  pcf_pkg::cmd_t    cmd;
  pcf_pkg::status_t status;

  // Sequence the set: accumulate, run the arithmetic steps, hand over the result.
  pcf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd),
    .in_stall    (in_stall),
    .out_valid   (out_valid)
  );

  // Hold the sums and do the arithmetic.
  pcf_datapath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .correlation (correlation),
    .pair_count  (pair_count),
    .degenerate  (degenerate),
    .overflowed  (overflowed)
  );

  // A result load always raises the output valid.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("result load did not raise out_valid");

  // No unit finishes in the cycle right after being started.
  a_go_not_done: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> !status.done)
    else $error("arithmetic unit finished too early");

  // Units only run while the input is held off.
  a_no_done_while_open: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !status.done)
    else $error("arithmetic unit finished while accepting pairs");

  // Never accept a pair and load a result together.
  a_no_accept_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.accum)
    else $error("pair accepted during result load");

endmodule
`default_nettype wire

/* test/tb_pearson_correlation_fixed_core.sv */
// Testbench for the fixed-point Pearson correlation core.
`timescale 1ns / 1ps
module tb_pearson_correlation_fixed_core;

  localparam int MAX_PAIRS   = pcf_pkg::DEF_MAX_PAIRS;
  localparam int SAMPLE_BITS = pcf_pkg::DEF_SAMPLE_BITS;
  localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 600;  // margin over the worst-case closing time
  localparam int LONG_HOLD   = 1500;

  typedef struct {
    logic signed [pcf_pkg::CORR_W-1:0] corr;
    logic [CNT_W-1:0]                  count;
    logic                              degen;
    logic                              ovf;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_BITS-1:0] x_sample = '0;
  logic signed [SAMPLE_BITS-1:0] y_sample = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pcf_pkg::CORR_W-1:0] correlation;
  logic [CNT_W-1:0] pair_count;
  logic degenerate;
  logic overflowed;

  // Running sums mirrored from the core, cleared after each set.
  longint acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
  bit     acc_full;

  corr_result_t expected_q[$];
  int  errors = 0;
  int  sets_closed = 0;
  int  pairs_sent = 0;
  int  degen_seen = 0;
  int  cycles = 0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  bit  long_hold_req = 1'b0;
  int  stall_left = 0;

  pearson_correlation_fixed_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_sample(x_sample), .y_sample(y_sample), .last_sample(last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .correlation(correlation), .pair_count(pair_count),
    .degenerate(degenerate), .overflowed(overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one accepted pair into the sums; on a closing pair, queue the coefficient.
  task automatic accumulate_pair(input logic signed [SAMPLE_BITS-1:0] x,
                                 input logic signed [SAMPLE_BITS-1:0] y, input bit last);
    longint xl, yl;
    logic signed [255:0] n, sx, sy, cov, vx, vy, mag, prod, lim, cand;
    int q;
    corr_result_t r;
    xl = longint'(x);
    yl = longint'(y);
    if (acc_n < MAX_PAIRS) begin
      acc_n++;
      acc_sx += xl;
      acc_sy += yl;
      acc_sxx += xl * xl;
      acc_syy += yl * yl;
      acc_sxy += xl * yl;
    end else begin
      acc_full = 1'b1;
    end
    if (!last) return;
    n = 256'(acc_n);
    sx = 256'(acc_sx);
    sy = 256'(acc_sy);
    cov = n * $signed(256'(acc_sxy)) - sx * sy;
    vx = n * $signed(256'(acc_sxx)) - sx * sx;
    vy = n * $signed(256'(acc_syy)) - sy * sy;
    r.count = acc_n[CNT_W-1:0];
    r.ovf = acc_full;
    r.degen = (vx == 0) || (vy == 0);
    r.corr = '0;
    if (!r.degen) begin
      mag = (cov < 0) ? -cov : cov;
      prod = vx * vy;
      lim = (mag * mag) <<< 30;
      if ((prod <<< 30) <= lim) begin
        q = 32768;
      end else begin
        q = 0;
        for (int b = 14; b >= 0; b--) begin
          cand = 256'(q | (1 << b));
          if (cand * cand * prod <= lim) q = q | (1 << b);
        end
      end
      if (cov < 0) r.corr = pcf_pkg::CORR_W'(-q);
      else r.corr = (q > 32767) ? pcf_pkg::CORR_MAX : q[15:0];
    end
    expected_q.push_back(r);
    acc_n = 0; acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
    acc_full = 1'b0;
  endtask

  // Offer one request, with an optional random gap first; hold it until accepted.
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] y, input bit last);
    int gap;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= x;
    y_sample <= y;
    last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    accumulate_pair(x, y, last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // single pair: zero variance
    send_pair(16'sd5, -16'sd7, 1'b1);
    // perfect positive correlation clamps to the top code
    for (int i = 1; i <= 4; i++) send_pair(SAMPLE_BITS'(i), SAMPLE_BITS'(i), i == 4);
    // perfect negative correlation reaches the bottom code
    for (int i = 1; i <= 4; i++) send_pair(SAMPLE_BITS'(i), SAMPLE_BITS'(-i), i == 4);
    // field extremes
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 1'b0);
    send_pair(-16'sd32768, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    // constant x: degenerate although y varies
    send_pair(-16'sd1, 16'sd100, 1'b0);
    send_pair(-16'sd1, -16'sd3, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b1);
    // partial correlation
    send_pair(16'sd0, 16'sd1, 1'b0);
    send_pair(16'sd1, 16'sd3, 1'b0);
    send_pair(16'sd2, 16'sd2, 1'b0);
    send_pair(16'sd3, 16'sd5, 1'b1);
    wait_drained();
  endtask

  task automatic send_random_set(input int len);
    int mode, span;
    logic signed [SAMPLE_BITS-1:0] x, y;
    mode = $urandom_range(0, 3);
    span = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          x = SAMPLE_BITS'($urandom);
          y = SAMPLE_BITS'($urandom);
        end
        1: begin
          x = SAMPLE_BITS'(int'($urandom_range(0, 2 ** span)) - (2 ** (span - 1)));
          y = x + SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
        end
        2: begin
          x = SAMPLE_BITS'($urandom);
          y = -x;
        end
        default: begin
          x = SAMPLE_BITS'($urandom_range(0, 3));
          y = SAMPLE_BITS'($urandom_range(0, 3));
        end
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic test_random(input int items);
    int done_items, len;
    done_items = 0;
    while (done_items < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_random_set(len);
      done_items += len;
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    // hold the output long enough that the core fills and stalls its input
    long_hold_req = 1'b1;
    for (int s = 0; s < 6; s++) send_random_set(3);
    wait_drained();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    cycles++;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each taken result against the oldest queued expectation.
  always @(posedge clk) begin
    corr_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result corr=%0d count=%0d", $time, correlation, pair_count);
        errors++;
      end else begin
        e = expected_q.pop_front();
        sets_closed++;
        if (e.degen) degen_seen++;
        if (correlation !== e.corr) begin
          $display("%0t: correlation expected %0d actual %0d", $time, e.corr, correlation);
          errors++;
        end
        if (pair_count !== e.count) begin
          $display("%0t: pair_count expected %0d actual %0d", $time, e.count, pair_count);
          errors++;
        end
        if (degenerate !== e.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degenerate);
          errors++;
        end
        if (overflowed !== e.ovf) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, e.ovf, overflowed);
          errors++;
        end
      end
    end
  end

  // Give up on a hung core.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("tb_pearson_correlation_fixed_core: errors");
      $finish;
    end
  end

  initial begin
    acc_n = 0; acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
    acc_full = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    // quiet tail: no idling on either side
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(80);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d pairs in %0d sets (%0d degenerate), field extremes,",
             pairs_sent, sets_closed, degen_seen);
    $display("random stalls on both sides and a long output hold that filled the core");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_pearson_correlation_fixed_core: clean");
    end else begin
      $display("tb_pearson_correlation_fixed_core: errors");
    end
    $finish;
  end

endmodule
